[design/kwt_pkg.sv]
// Shared types and constants for the keyword/number tokenizer.
package kwt_pkg;

	localparam int PosBits  = 32;
	localparam int QueDepth = 4;
	localparam int QuePtrW  = $clog2(QueDepth);

	localparam logic [62:0] ValueTop = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] KwFn     = 32'h0000_666E;
	localparam logic [31:0] KwAuto   = 32'h6175_746F;
	localparam logic [31:0] KwRet    = 32'h0072_6574;

	typedef logic [PosBits-1:0] pos_t;

	typedef enum logic [3:0] {
		KIND_END    = 4'd0,
		KIND_IDENT  = 4'd1,
		KIND_NUMBER = 4'd2,
		KIND_FN     = 4'd3,
		KIND_AUTO   = 4'd4,
		KIND_RET    = 4'd5,
		KIND_LPAREN = 4'd6,
		KIND_RPAREN = 4'd7,
		KIND_LBRACE = 4'd8,
		KIND_RBRACE = 4'd9,
		KIND_SEMI   = 4'd10,
		KIND_ASSIGN = 4'd11,
		KIND_PLUS   = 4'd12
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_CHAR  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CLS_SPACE = 3'd0,
		CLS_WORD  = 3'd1,
		CLS_DIGIT = 3'd2,
		CLS_PUNCT = 3'd3,
		CLS_OTHER = 3'd4
	} cls_t;

	// One classified source byte
	typedef struct packed {
		logic [7:0] byte_val;
		cls_t       cls;
		kind_t      punct;
		logic [3:0] digit;
		pos_t       pos;
		logic       eoi;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [31:0] len;
		logic [62:0] value;
		err_t        err;
		logic        last;
	} res_t;

endpackage

[design/keyword_number_tokenizer.sv]
// Path: an accepted byte is written into the byte queue; the back end then writes its result
// into the result buffer that drives the outputs. A closing byte's second result follows on replay.
// Throughput: one source byte per cycle while the byte queue is not full and the result buffer has
// room; a byte that closes a token and yields a result of its own is processed twice, once per result,
// through a one-result-per-cycle result buffer of two entries.
// Reset: arst_n clears the scan mode, halt flag, position counter and both queues at once.
// After an error or an End beat the block drops every input until reset.
module keyword_number_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  token_kind,
	output logic [31:0] start_position,
	output logic [31:0] token_length,
	output logic [62:0] number_value,
	output logic [1:0]  error_code,
	output logic        last_result
);

	logic           wr, rd, q_empty;
	kwt_pkg::item_t wr_item, rd_item;
	kwt_pkg::res_t  res;

	kwt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.source_byte  (source_byte),
		.end_of_input (end_of_input),
		.wr           (wr),
		.item         (wr_item)
	);

	kwt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_item (wr_item),
		.full    (full),
		.rd      (rd),
		.rd_item (rd_item),
		.empty   (q_empty)
	);

	kwt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (!q_empty),
		.item   (rd_item),
		.take   (rd),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	assign token_kind     = res.kind;
	assign start_position = res.start;
	assign token_length   = res.len;
	assign number_value   = res.value;
	assign error_code     = res.err;
	assign last_result    = res.last;

endmodule

[design/kwt_front.sv]
// Front end: byte classification and position tagging.
module kwt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  logic [7:0]      source_byte,
	input  logic            end_of_input,
	output logic            wr,
	output kwt_pkg::item_t  item
);

	kwt_pkg::pos_t pos_q;

	assign wr = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr && !end_of_input) begin
			pos_q <= pos_q + kwt_pkg::pos_t'(1);
		end
	end

	always_comb begin
		item.byte_val = source_byte;
		item.pos      = pos_q;
		item.eoi      = end_of_input;
		item.digit    = source_byte[3:0];
		item.punct    = kwt_pkg::KIND_END;
		item.cls      = kwt_pkg::CLS_OTHER;
		case (source_byte) inside
			8'h20, [8'h09:8'h0D]: item.cls = kwt_pkg::CLS_SPACE;
			[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: item.cls = kwt_pkg::CLS_WORD;
			[8'h30:8'h39]: item.cls = kwt_pkg::CLS_DIGIT;
			8'h28: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_LPAREN;
			end
			8'h29: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_RPAREN;
			end
			8'h7B: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_LBRACE;
			end
			8'h7D: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_RBRACE;
			end
			8'h3B: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_SEMI;
			end
			8'h3D: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_ASSIGN;
			end
			8'h2B: begin
				item.cls   = kwt_pkg::CLS_PUNCT;
				item.punct = kwt_pkg::KIND_PLUS;
			end
			default: item.cls = kwt_pkg::CLS_OTHER;
		endcase
	end

endmodule

[design/kwt_queue.sv]
// Short queue of classified bytes between front and back end.
module kwt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  kwt_pkg::item_t  wr_item,
	output logic            full,
	input  logic            rd,
	output kwt_pkg::item_t  rd_item,
	output logic            empty
);

	kwt_pkg::item_t                  mem_q [kwt_pkg::QueDepth];
	logic [kwt_pkg::QuePtrW-1:0]     wp_q;
	logic [kwt_pkg::QuePtrW-1:0]     rp_q;
	logic [kwt_pkg::QuePtrW:0]       cnt_q;

	assign full    = (cnt_q == (kwt_pkg::QuePtrW+1)'(kwt_pkg::QueDepth));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/kwt_back.sv]
// Back end: token state, number accumulation and the result buffer.
module kwt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            avail,
	input  kwt_pkg::item_t  item,
	output logic            take,
	input  logic            pop,
	output logic            empty,
	output kwt_pkg::res_t   res
);

	kwt_pkg::mode_t mode_q, mode_d;
	logic           halted_q;
	kwt_pkg::pos_t  tok_start_q;
	logic [31:0]    tok_bytes_q;
	logic [62:0]    acc_q;
	logic           ovf_q;
	logic [31:0]    prefix_q;

	kwt_pkg::res_t  buf_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	logic           pop_fire, room, go;
	logic           cont, flush, flush_err, second, split, emit, halt_set;
	logic           start_word, start_digit;
	logic [67:0]    sum;
	logic [31:0]    bytes_inc;
	kwt_pkg::kind_t ident_kind;
	kwt_pkg::res_t  flush_res, second_res, new_res;

	assign pop_fire = pop && (cnt_q != 2'd0);
	assign room     = (cnt_q != 2'd2) || pop_fire;
	assign go       = avail && room;
	assign empty    = (cnt_q == 2'd0);
	assign res      = buf_q[rp_q];

	assign cont = !item.eoi && (
		(mode_q == kwt_pkg::MODE_IDENT &&
			(item.cls == kwt_pkg::CLS_WORD || item.cls == kwt_pkg::CLS_DIGIT)) ||
		(mode_q == kwt_pkg::MODE_NUMBER && item.cls == kwt_pkg::CLS_DIGIT));
	assign flush     = (mode_q != kwt_pkg::MODE_IDLE) && !cont;
	assign flush_err = flush && (mode_q == kwt_pkg::MODE_NUMBER) && ovf_q;
	assign second    = item.eoi || item.cls == kwt_pkg::CLS_PUNCT ||
		item.cls == kwt_pkg::CLS_OTHER;
	// A closing byte with a result of its own: emit the pending token first, replay the byte
	assign split     = flush && !flush_err && second;
	assign take      = go && !split;
	assign emit      = go && !halted_q && !cont && (flush || second);
	assign halt_set  = go && !halted_q && !cont && (flush_err ||
		(!flush && (item.eoi || item.cls == kwt_pkg::CLS_OTHER)));
	assign start_word  = take && !halted_q && !cont && !flush_err && !item.eoi &&
		item.cls == kwt_pkg::CLS_WORD;
	assign start_digit = take && !halted_q && !cont && !flush_err && !item.eoi &&
		item.cls == kwt_pkg::CLS_DIGIT;

	assign sum = ({5'b0, acc_q} << 3) + ({5'b0, acc_q} << 1) + 68'(item.digit);
	assign bytes_inc = (tok_bytes_q != 32'hFFFF_FFFF) ? tok_bytes_q + 32'd1 : tok_bytes_q;

	always_comb begin
		ident_kind = kwt_pkg::KIND_IDENT;
		if (tok_bytes_q == 32'd2 && prefix_q == kwt_pkg::KwFn) begin
			ident_kind = kwt_pkg::KIND_FN;
		end else if (tok_bytes_q == 32'd4 && prefix_q == kwt_pkg::KwAuto) begin
			ident_kind = kwt_pkg::KIND_AUTO;
		end else if (tok_bytes_q == 32'd3 && prefix_q == kwt_pkg::KwRet) begin
			ident_kind = kwt_pkg::KIND_RET;
		end
	end

	// Next scan mode
	always_comb begin
		mode_d = mode_q;
		if (go && !halted_q && !cont) begin
			if (start_word) begin
				mode_d = kwt_pkg::MODE_IDENT;
			end else if (start_digit) begin
				mode_d = kwt_pkg::MODE_NUMBER;
			end else begin
				mode_d = kwt_pkg::MODE_IDLE;
			end
		end
	end

	// Result formation
	always_comb begin
		flush_res.kind  = ident_kind;
		flush_res.start = 32'(tok_start_q);
		flush_res.len   = tok_bytes_q;
		flush_res.value = '0;
		flush_res.err   = kwt_pkg::ERR_NONE;
		flush_res.last  = 1'b1;
		if (mode_q == kwt_pkg::MODE_NUMBER) begin
			if (ovf_q) begin
				flush_res.kind = kwt_pkg::KIND_END;
				flush_res.len  = '0;
				flush_res.err  = kwt_pkg::ERR_RANGE;
			end else begin
				flush_res.kind  = kwt_pkg::KIND_NUMBER;
				flush_res.value = acc_q;
			end
		end

		second_res.kind  = kwt_pkg::KIND_END;
		second_res.start = 32'(item.pos);
		second_res.len   = '0;
		second_res.value = '0;
		second_res.err   = kwt_pkg::ERR_NONE;
		second_res.last  = 1'b1;
		if (!item.eoi) begin
			if (item.cls == kwt_pkg::CLS_PUNCT) begin
				second_res.kind = item.punct;
				second_res.len  = 32'd1;
			end else begin
				second_res.err = kwt_pkg::ERR_CHAR;
			end
		end

		new_res      = flush ? flush_res : second_res;
		new_res.last = !split;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= kwt_pkg::MODE_IDLE;
			halted_q    <= 1'b0;
			tok_start_q <= '0;
			tok_bytes_q <= '0;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			prefix_q    <= '0;
		end else begin
			mode_q <= mode_d;
			if (halt_set) begin
				halted_q <= 1'b1;
			end
			if (go && !halted_q && cont) begin
				tok_bytes_q <= bytes_inc;
				if (mode_q == kwt_pkg::MODE_IDENT) begin
					if (tok_bytes_q < 32'd4) begin
						prefix_q <= {prefix_q[23:0], item.byte_val};
					end
				end else if (!ovf_q) begin
					if (sum > 68'(kwt_pkg::ValueTop)) begin
						ovf_q <= 1'b1;
					end else begin
						acc_q <= sum[62:0];
					end
				end
			end else if (start_word || start_digit) begin
				tok_start_q <= item.pos;
				tok_bytes_q <= 32'd1;
				prefix_q    <= {24'b0, item.byte_val};
				acc_q       <= 63'(item.digit);
				ovf_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			buf_q[wp_q] <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (emit) begin
				wp_q <= !wp_q;
			end
			if (pop_fire) begin
				rp_q <= !rp_q;
			end
			case ({emit, pop_fire})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/kwt_checker.sv]
// Port-level checks on the tokenizer's result stream, bound to the top level.
module kwt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic [3:0]  token_kind,
	input logic [31:0] token_length,
	input logic [62:0] number_value,
	input logic [1:0]  error_code,
	input logic        last_result
);

	// Errors carry no kind and no length
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error_code != kwt_pkg::ERR_NONE) |->
		(token_kind == kwt_pkg::KIND_END && token_length == 32'd0))
		else $error("error result with token fields set");

	// End and errors close the stream for this beat
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind == kwt_pkg::KIND_END) |-> last_result)
		else $error("End or error result not marked last");

	// Only number tokens carry a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind != kwt_pkg::KIND_NUMBER) |-> (number_value == 63'd0))
		else $error("value on a non-number result");

	// Single-character tokens are one byte long
	a_punct_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind >= kwt_pkg::KIND_LPAREN) |-> (token_length == 32'd1))
		else $error("single-character token with wrong length");

	// Every token other than End is non-empty
	a_word_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind != kwt_pkg::KIND_END) |-> (token_length != 32'd0))
		else $error("token with zero length");

endmodule

bind keyword_number_tokenizer kwt_checker u_kwt_checker (.*);
